### rtl/hidden_record_bit_extractor_defines.svh
// assertion macros used by hre_checker
`ifndef HIDDEN_RECORD_BIT_EXTRACTOR_DEFINES_SVH
`define HIDDEN_RECORD_BIT_EXTRACTOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define HRE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hre check failed: same-cycle rule");

// next-cycle implication, disabled during reset
`define HRE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hre check failed: next-cycle rule");

`endif

### rtl/hre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hre_pkg
// Shared widths, codes and types for the hidden record bit extractor.
// ----------------------------------------------------------------------------
package hre_pkg;

    localparam int VALUE_W   = 16;
    localparam int MB_W      = 18;
    localparam int BYTE_W    = 8;
    localparam int REC_W     = 16;
    localparam int COUNT_W   = 17;
    localparam int SIZE_W    = 32;
    localparam int ERR_W     = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = COUNT_W;

    // stream data widths, padded to whole bytes
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    localparam logic [BYTE_W-1:0] MARKER_BYTE = 8'h24;

    // bit selection codes carried in s_tuser
    localparam logic OP_LOW_BIT = 1'b0;
    localparam logic OP_SIGN    = 1'b1;

    // sticky error codes
    localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
    localparam logic [ERR_W-1:0] ERR_MARKER = 2'd1;
    localparam logic [ERR_W-1:0] ERR_RECORD = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RECORD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_COUNT  = 1'd1;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } pack_byte_t;

endpackage

### rtl/hre_bit_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hre_bit_pack
// Recovers the hidden bit of each carrier value and packs bits MSB first.
// ----------------------------------------------------------------------------
module hre_bit_pack
    import hre_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               op,
    input  logic [VALUE_W-1:0] carrier_value,
    output pack_byte_t         byte_out
);

    logic [2:0]        bit_count_reg;
    logic [2:0]        bit_count_next;
    logic [BYTE_W-1:0] byte_accum_reg;
    logic [BYTE_W-1:0] byte_accum_next;
    logic              hidden_bit;
    logic [BYTE_W-1:0] merged;

    always_comb
    begin
        unique case (op)
            OP_LOW_BIT: hidden_bit = carrier_value[0];
            OP_SIGN:    hidden_bit = ~carrier_value[VALUE_W-1];
            default:    hidden_bit = 1'b0;
        endcase
    end

    assign merged = byte_accum_reg | (BYTE_W'(hidden_bit) << (3'd7 - bit_count_reg));

    always_comb
    begin
        bit_count_next  = bit_count_reg;
        byte_accum_next = byte_accum_reg;
        if (step)
        begin
            bit_count_next = bit_count_reg + 3'd1;
            // a full byte restarts the accumulator
            byte_accum_next = (bit_count_reg == 3'd7) ? '0 : merged;
        end
    end

    assign byte_out.valid = (bit_count_reg == 3'd7);
    assign byte_out.data  = merged;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg  <= '0;
            byte_accum_reg <= '0;
        end
        else
        begin
            bit_count_reg  <= bit_count_next;
            byte_accum_reg <= byte_accum_next;
        end
    end

endmodule

### rtl/hre_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hre_parser
// Record parser driven by completed bytes; holds the result register.
// ----------------------------------------------------------------------------
module hre_parser
    import hre_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 step,
    input  pack_byte_t           byte_in,
    input  logic [MB_W-1:0]      mb_address,
    input  logic                 out_ready,
    output logic                 done,
    output logic                 out_valid,
    output logic [BYTE_W-1:0]    data_byte,
    output logic                 payload_valid,
    output logic                 record_done,
    output logic [ERR_W-1:0]     error_code,
    output logic                 finished,
    output logic [MB_W-1:0]      next_allowed_mb
);

    typedef enum logic [3:0] {
        ST_MARK1   = 4'd0,
        ST_REC_HI  = 4'd1,
        ST_REC_LO  = 4'd2,
        ST_MARK2   = 4'd3,
        ST_SIZE0   = 4'd4,
        ST_SIZE1   = 4'd5,
        ST_SIZE2   = 4'd6,
        ST_SIZE3   = 4'd7,
        ST_PAYLOAD = 4'd8
    } state_t;

    state_t             state_reg,    state_next;
    logic [REC_W-1:0]   target_reg,   target_next;
    logic [COUNT_W-1:0] count_reg,    count_next;
    logic [REC_W-1:0]   seen_reg,     seen_next;
    logic [REC_W-1:0]   expected_reg, expected_next;
    logic [SIZE_W-1:0]  left_reg,     left_next;
    logic               target_hit_reg, target_hit_next;
    logic               done_reg,     done_next;
    logic [ERR_W-1:0]   error_reg,    error_next;
    logic [MB_W-1:0]    allowed_reg,  allowed_next;
    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  data_reg,     data_next;
    logic               payload_reg,  payload_next;
    logic               rec_end_reg,  rec_end_next;

    logic [BYTE_W-1:0]  b;
    logic [REC_W-1:0]   rec_num;
    logic [SIZE_W-1:0]  left_dec;

    assign b        = byte_in.data;
    // or-ed in, so a retry after a mismatch keeps the low bits seen before
    assign rec_num  = seen_reg | {{(REC_W-BYTE_W){1'b0}}, b};
    assign left_dec = left_reg - SIZE_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        target_next     = target_reg;
        count_next      = count_reg;
        seen_next       = seen_reg;
        expected_next   = expected_reg;
        left_next       = left_reg;
        target_hit_next = target_hit_reg;
        done_next       = done_reg;
        error_next      = error_reg;
        allowed_next    = allowed_reg;
        out_valid_next  = out_valid_reg;
        data_next       = data_reg;
        payload_next    = payload_reg;
        rec_end_next    = rec_end_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TARGET_RECORD: target_next = cfg_data[REC_W-1:0];
                CFG_RECORD_COUNT:  count_next  = cfg_data;
                default:           ;
            endcase
        end

        if (step && byte_in.valid && !done_reg)
        begin
            out_valid_next = 1'b1;
            data_next      = b;
            payload_next   = 1'b0;
            rec_end_next   = 1'b0;
            unique case (state_reg)
                ST_MARK1, ST_MARK2:
                begin
                    // bad marker keeps the parser waiting for the same marker
                    if (b != MARKER_BYTE)
                        error_next = ERR_MARKER;
                    else
                        state_next = (state_reg == ST_MARK1) ? ST_REC_HI : ST_SIZE0;
                end
                ST_REC_HI:
                begin
                    seen_next  = {b, 8'h00};
                    state_next = ST_REC_LO;
                end
                ST_REC_LO:
                begin
                    seen_next = rec_num;
                    if (rec_num == expected_reg)
                    begin
                        if (rec_num == target_reg)
                            target_hit_next = 1'b1;
                        state_next = ST_MARK2;
                    end
                    else
                    begin
                        error_next = ERR_RECORD;
                    end
                end
                ST_SIZE0, ST_SIZE1, ST_SIZE2, ST_SIZE3:
                begin
                    left_next  = {left_reg[SIZE_W-BYTE_W-1:0], b};
                    state_next = state_t'(state_reg + 4'd1);
                end
                ST_PAYLOAD:
                begin
                    left_next    = left_dec;
                    payload_next = target_hit_reg;
                    if (left_dec == '0)
                    begin
                        rec_end_next  = 1'b1;
                        if (target_hit_reg)
                        begin
                            done_next       = 1'b1;
                            target_hit_next = 1'b0;
                        end
                        expected_next = expected_reg + REC_W'(1);
                        state_next    = ST_MARK1;
                        allowed_next  = mb_address + MB_W'(1);
                        // last record by count
                        if ({1'b0, seen_reg} + COUNT_W'(1) == count_reg)
                            done_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_MARK1;
            target_reg     <= '0;
            count_reg      <= COUNT_W'(1);
            seen_reg       <= '0;
            expected_reg   <= '0;
            left_reg       <= '0;
            target_hit_reg <= 1'b0;
            done_reg       <= 1'b0;
            error_reg      <= ERR_NONE;
            allowed_reg    <= '0;
            out_valid_reg  <= 1'b0;
            data_reg       <= '0;
            payload_reg    <= 1'b0;
            rec_end_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            target_reg     <= target_next;
            count_reg      <= count_next;
            seen_reg       <= seen_next;
            expected_reg   <= expected_next;
            left_reg       <= left_next;
            target_hit_reg <= target_hit_next;
            done_reg       <= done_next;
            error_reg      <= error_next;
            allowed_reg    <= allowed_next;
            out_valid_reg  <= out_valid_next;
            data_reg       <= data_next;
            payload_reg    <= payload_next;
            rec_end_reg    <= rec_end_next;
        end
    end

    // sticky state only moves with a result, so it stays aligned with the held result
    assign done            = done_reg;
    assign out_valid       = out_valid_reg;
    assign data_byte       = data_reg;
    assign payload_valid   = payload_reg;
    assign record_done     = rec_end_reg;
    assign error_code      = error_reg;
    assign finished        = done_reg;
    assign next_allowed_mb = allowed_reg;

endmodule

### rtl/hidden_record_bit_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hidden_record_bit_extractor
// Pulls hidden bits from carrier values and extracts one embedded record.
// ----------------------------------------------------------------------------
// Input stream: one carrier value per transfer, s_tuser selects how the
// hidden bit is read (low bit or sign). Eight transfers build one byte.
// Output stream: one transfer per completed byte, m_tlast marks the last
// byte of a record, m_tuser flags payload of the target record.
// An item is taken every cycle while s_tready is high; it is held in the input
// register and its result, if any, is loaded into the result register, which
// drives m_tvalid. Throughput is one item per cycle while the result register
// is free or draining. When the receiver stalls, the result register holds
// and the input register fills, then s_tready drops; items that complete no
// byte keep flowing only while the result register is free or draining.
// Reset clears the packer and parser; target_record returns to 0 and
// record_count to 1. After extraction ends, input transfers are accepted
// and dropped. Configuration writes are taken at any cycle via cfg_we.
// ----------------------------------------------------------------------------
module hidden_record_bit_extractor
    import hre_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // carrier_value, mb_address, zero pad
    input  logic                 s_tuser,   // op
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // data_byte, error_code, finished,
                                            // next_allowed_mb, zero pad
    output logic                 m_tlast,
    output logic                 m_tuser    // payload_valid
);

    logic               in_valid_reg, in_valid_next;
    logic               in_op_reg;
    logic [VALUE_W-1:0] in_value_reg;
    logic [MB_W-1:0]    in_mb_reg;
    logic               advance;
    logic               done;
    pack_byte_t         pack_byte;
    logic [BYTE_W-1:0]  data_byte;
    logic [ERR_W-1:0]   error_code;
    logic               finished;
    logic [MB_W-1:0]    next_allowed_mb;

    assign advance  = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg    <= s_tuser;
            in_value_reg <= s_tdata[VALUE_W-1:0];
            in_mb_reg    <= s_tdata[VALUE_W+MB_W-1:VALUE_W];
        end
    end

    hre_bit_pack u_bit_pack (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance && !done),
        .op            (in_op_reg),
        .carrier_value (in_value_reg),
        .byte_out      (pack_byte)
    );

    hre_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .step            (advance),
        .byte_in         (pack_byte),
        .mb_address      (in_mb_reg),
        .out_ready       (m_tready),
        .done            (done),
        .out_valid       (m_tvalid),
        .data_byte       (data_byte),
        .payload_valid   (m_tuser),
        .record_done     (m_tlast),
        .error_code      (error_code),
        .finished        (finished),
        .next_allowed_mb (next_allowed_mb)
    );

    assign m_tdata = {{(M_TDATA_W-BYTE_W-ERR_W-1-MB_W){1'b0}},
                      next_allowed_mb, finished, error_code, data_byte};

endmodule

### rtl/hre_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hre_checker
// Port-level checks on the result stream of the extractor.
// ----------------------------------------------------------------------------
`include "hidden_record_bit_extractor_defines.svh"

module hre_checker
    import hre_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast,
    input logic                 m_tuser
);

    logic m_xfer;

    assign m_xfer = m_tvalid && m_tready;

    // stalled result holds
    `HRE_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // nothing follows the transfer that reports the end of extraction
    `HRE_ASSERT_NEXT(a_quiet_after_finish, m_xfer && m_tdata[10], !m_tvalid)

    // an error once reported stays reported
    `HRE_ASSERT_NEXT(a_error_sticky, m_xfer && (m_tdata[9:8] != ERR_NONE),
                     !m_tvalid || (m_tdata[9:8] != ERR_NONE))

    // the last payload byte of the target record ends extraction
    `HRE_ASSERT_NOW(a_target_end, m_tvalid && m_tuser && m_tlast, m_tdata[10])

endmodule

bind hidden_record_bit_extractor hre_checker u_hre_checker (.*);

### tb/hre_record_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hre_record_checker
// Watches the configuration port and both streams of the extractor. It keeps
// its own copy of the bit packer and record parser, works out the byte
// transfer that each input transfer completes, and compares every output
// transfer field by field with the oldest one still owed.
// ----------------------------------------------------------------------------
module hre_record_checker
    import hre_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // carrier_value, mb_address, zero pad
    input  logic                 s_tuser,   // op
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,   // data_byte, error_code, finished,
                                            // next_allowed_mb, zero pad
    input  logic                 m_tlast,
    input  logic                 m_tuser,   // payload_valid
    output int                   mismatches,
    output int                   backlog
);

    // field offsets inside m_tdata
    localparam int ERR_LSB = BYTE_W;
    localparam int FIN_BIT = ERR_LSB + ERR_W;
    localparam int MB_LSB  = FIN_BIT + 1;
    localparam int PAD_LSB = MB_LSB + MB_W;

    typedef enum logic [3:0] {
        WANT_MARK_A,
        WANT_REC_HI,
        WANT_REC_LO,
        WANT_MARK_B,
        WANT_SIZE_3,
        WANT_SIZE_2,
        WANT_SIZE_1,
        WANT_SIZE_0,
        WANT_PAYLOAD
    } parse_phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              payload_valid;
        logic              record_done;
        logic [ERR_W-1:0]  error_code;
        logic              finished;
        logic [MB_W-1:0]   next_allowed_mb;
    } byte_result_t;

    byte_result_t owed_bytes[$];

    logic [REC_W-1:0]   target_rec;
    logic [COUNT_W-1:0] record_total;
    logic [3:0]         bits_in;
    logic [BYTE_W-1:0]  assembled;
    parse_phase_t       phase;
    logic [REC_W-1:0]   rec_seen;
    logic [REC_W-1:0]   rec_next;
    logic [SIZE_W-1:0]  size_left;
    logic               in_target;
    logic               stopped;
    logic [ERR_W-1:0]   sticky_err;
    logic [MB_W-1:0]    resume_mb;

    task automatic flag_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
        mismatches++;
        $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    endtask

    task automatic absorb_item(input logic op, input logic [VALUE_W-1:0] value,
                               input logic [MB_W-1:0] mb);
        logic              hidden;
        logic [BYTE_W-1:0] b;
        byte_result_t      r;
        if (stopped)
            return;
        hidden = (op == OP_LOW_BIT) ? value[0] : ~value[VALUE_W-1];
        // msb first
        if (hidden)
            assembled[3'd7 - bits_in[2:0]] = 1'b1;
        bits_in = bits_in + 4'd1;
        if (bits_in < 4'd8)
            return;
        b = assembled;
        r.payload_valid = 1'b0;
        r.record_done   = 1'b0;
        case (phase)
            WANT_MARK_A, WANT_MARK_B:
            begin
                // a bad marker leaves the parser where it is
                if (b != MARKER_BYTE)
                    sticky_err = ERR_MARKER;
                else
                    phase = parse_phase_t'(phase + 4'd1);
            end
            WANT_REC_HI:
            begin
                rec_seen = {b, 8'h00};
                phase    = WANT_REC_LO;
            end
            WANT_REC_LO:
            begin
                // or-ed in, so a retry after a mismatch keeps the earlier bits
                rec_seen = rec_seen | {8'h00, b};
                if (rec_seen == rec_next)
                begin
                    if (rec_seen == target_rec)
                        in_target = 1'b1;
                    phase = WANT_MARK_B;
                end
                else
                begin
                    sticky_err = ERR_RECORD;
                end
            end
            WANT_SIZE_3, WANT_SIZE_2, WANT_SIZE_1, WANT_SIZE_0:
            begin
                size_left = {size_left[SIZE_W-BYTE_W-1:0], b};
                phase     = parse_phase_t'(phase + 4'd1);
            end
            WANT_PAYLOAD:
            begin
                // a zero size wraps here and the record runs on
                size_left       = size_left - 1'b1;
                r.payload_valid = in_target;
                if (size_left == '0)
                begin
                    r.record_done = 1'b1;
                    if (in_target)
                    begin
                        stopped   = 1'b1;
                        in_target = 1'b0;
                    end
                    rec_next  = rec_next + 1'b1;
                    phase     = WANT_MARK_A;
                    resume_mb = mb + 1'b1;
                    if ({1'b0, rec_seen} + 1'b1 == record_total)
                        stopped = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        bits_in   = '0;
        assembled = '0;
        r.data_byte       = b;
        r.error_code      = sticky_err;
        r.finished        = stopped;
        r.next_allowed_mb = resume_mb;
        owed_bytes.push_back(r);
    endtask

    task automatic check_transfer();
        byte_result_t want;
        if (owed_bytes.size() == 0)
        begin
            flag_mismatch("byte transfer with none owed", m_tdata, 0);
            return;
        end
        want = owed_bytes.pop_front();
        if (m_tdata[BYTE_W-1:0] != want.data_byte)
            flag_mismatch("data_byte", m_tdata[BYTE_W-1:0], want.data_byte);
        if (m_tuser != want.payload_valid)
            flag_mismatch("payload_valid", m_tuser, want.payload_valid);
        if (m_tlast != want.record_done)
            flag_mismatch("record_done", m_tlast, want.record_done);
        if (m_tdata[ERR_LSB +: ERR_W] != want.error_code)
            flag_mismatch("error_code", m_tdata[ERR_LSB +: ERR_W], want.error_code);
        if (m_tdata[FIN_BIT] != want.finished)
            flag_mismatch("finished", m_tdata[FIN_BIT], want.finished);
        if (m_tdata[MB_LSB +: MB_W] != want.next_allowed_mb)
            flag_mismatch("next_allowed_mb", m_tdata[MB_LSB +: MB_W], want.next_allowed_mb);
        if (m_tdata[M_TDATA_W-1:PAD_LSB] != '0)
            flag_mismatch("tdata pad", m_tdata[M_TDATA_W-1:PAD_LSB], 0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_bytes.delete();
            target_rec   = '0;
            record_total = 17'd1;
            bits_in      = '0;
            assembled    = '0;
            phase        = WANT_MARK_A;
            rec_seen     = '0;
            rec_next     = '0;
            size_left    = '0;
            in_target    = 1'b0;
            stopped      = 1'b0;
            sticky_err   = ERR_NONE;
            resume_mb    = '0;
            backlog      = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_TARGET_RECORD)
                    target_rec = cfg_data[REC_W-1:0];
                else if (cfg_index == CFG_RECORD_COUNT)
                    record_total = cfg_data[COUNT_W-1:0];
            end
            if (m_tvalid && m_tready)
                check_transfer();
            if (s_tvalid && s_tready)
                absorb_item(s_tuser, s_tdata[VALUE_W-1:0], s_tdata[VALUE_W +: MB_W]);
            backlog = owed_bytes.size();
        end
    end

endmodule

### tb/tb_hidden_record_bit_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hidden_record_bit_extractor
// Feeds the extractor with carrier values that spell out a stream of embedded
// records, mostly well formed with random content, some with junk markers and
// record number mismatches. Settings change between phases while the block is
// idle; the run closes by extraction ending on the target, on the count, or on
// an open-ended record. Both sides idle at random; a checker does the scoring.
// ----------------------------------------------------------------------------
module tb_hidden_record_bit_extractor;
    import hre_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 4;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int S_PAD_W        = S_TDATA_W - VALUE_W - MB_W;
    localparam int MB_TOP         = 139263;

    typedef enum logic [1:0] {
        END_BY_TARGET,
        END_BY_COUNT,
        END_OPEN_SIZE
    } finale_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // carrier_value, mb_address, zero pad
    logic                 s_tuser   = 1'b0; // op
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // data_byte, error_code, finished,
                                            // next_allowed_mb, zero pad
    logic                 m_tlast;
    logic                 m_tuser;          // payload_valid

    int         mismatches;
    int         backlog;
    int         items_sent   = 0;
    int         stuck_cycles = 0;
    int         hold_asks    = 0;
    int         holds_done   = 0;
    logic [15:0] next_rec    = '0;
    bit         tx_gaps      = 1'b0;
    bit         rx_stalls    = 1'b0;
    bit         no_idling    = 1'b0;

    always #(HALF_PERIOD) clk = ~clk;

    hidden_record_bit_extractor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    hre_record_checker byte_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .backlog    (backlog)
    );

    function automatic logic [VALUE_W-1:0] carrier_for(input logic op, input logic hidden);
        logic [VALUE_W-1:0] v;
        v = VALUE_W'($urandom_range(0, 65535));
        case ($urandom_range(0, 5))
            0:
                v = hidden ? 16'h7FFF : 16'h8000;
            1:
            begin
                if (op == OP_LOW_BIT)
                    v = hidden ? 16'hFFFF : 16'h0000;
                else
                    v = hidden ? 16'h0000 : 16'hFFFF;
            end
            default:
            begin
                if (op == OP_LOW_BIT)
                    v[0] = hidden;
                else
                    v[VALUE_W-1] = ~hidden;
            end
        endcase
        return v;
    endfunction

    function automatic logic [MB_W-1:0] pick_mb();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return MB_W'(MB_TOP);
            default: return MB_W'($urandom_range(0, MB_TOP));
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] junk_byte();
        logic [BYTE_W-1:0] j;
        j = BYTE_W'($urandom_range(0, 255));
        if (j == MARKER_BYTE)
            j = ~j;
        return j;
    endfunction

    task automatic push_bit(input logic hidden);
        logic op;
        op = ($urandom_range(0, 1) == 0) ? OP_LOW_BIT : OP_SIGN;
        s_tuser  <= op;
        s_tdata  <= {{S_PAD_W{1'b0}}, pick_mb(), carrier_for(op, hidden)};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        if (tx_gaps && !no_idling && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    task automatic push_byte(input logic [BYTE_W-1:0] b);
        for (int i = BYTE_W - 1; i >= 0; i--)
            push_bit(b[i]);
    endtask

    // header, size msb first, body; flaws go in as extra bytes the parser rejects
    task automatic push_record(input logic [SIZE_W-1:0] rec_size, input int body_len,
                               input bit lead_junk, input bit bad_low, input bit mid_junk);
        logic [BYTE_W-1:0] low_part;
        if (lead_junk)
            push_byte(junk_byte());
        push_byte(MARKER_BYTE);
        push_byte(next_rec[15:8]);
        if (bad_low)
        begin
            // only bits of the right low byte, so the retry can still match
            low_part = next_rec[7:0] & BYTE_W'($urandom_range(0, 255));
            if (low_part == next_rec[7:0])
                low_part = '0;
            push_byte(low_part);
        end
        push_byte(next_rec[7:0]);
        if (mid_junk)
            push_byte(junk_byte());
        push_byte(MARKER_BYTE);
        for (int i = 3; i >= 0; i--)
            push_byte(rec_size[8*i +: 8]);
        repeat (body_len) push_byte(BYTE_W'($urandom_range(0, 255)));
        next_rec++;
    endtask

    task automatic push_random_record();
        int rec_size;
        rec_size = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 6);
        push_record(rec_size, rec_size, $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
                    $urandom_range(0, 9) == 0);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (backlog == 0);
        // an item that completes no byte may still be in the pipe
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // targets and counts stay clear of the records this run can reach
    function automatic logic [CFG_W-1:0] pick_target();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return 17'd65535;
            default: return CFG_W'($urandom_range(int'(next_rec) + 1000, 65535));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_count();
        case ($urandom_range(0, 4))
            0:       return 17'd1;
            1:       return '0;
            2:       return 17'd65536;
            3:       return 17'd131071;
            default: return CFG_W'($urandom_range(int'(next_rec) + 1000, 65536));
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stuck_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        wait (stuck_cycles >= WATCHDOG_LIMIT);
        $display("tb_hidden_record_bit_extractor: errors");
        $finish;
    end

    // receiver: random stall bursts, plus one long hold on request
    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_asks != holds_done)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holds_done++;
            end
            else if (rx_stalls && !no_idling && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        finale_t finale;
        int      phase_no;
        int      phase_end;
        int      rec_size;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_reg(CFG_TARGET_RECORD, 17'd65535);
        write_reg(CFG_RECORD_COUNT, 17'd65536);

        // clean record, then one with every kind of broken header
        push_record(32'd1, 1, 1'b0, 1'b0, 1'b0);
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        push_record(32'd2, 2, 1'b1, 1'b1, 1'b1);

        phase_no = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            settle();
            case (phase_no)
                0:
                begin
                    // both only matter for record 0, which is already past
                    write_reg(CFG_TARGET_RECORD, '0);
                    write_reg(CFG_RECORD_COUNT, 17'd1);
                end
                1:
                    write_reg(CFG_RECORD_COUNT, '0);
                2:
                    write_reg(CFG_RECORD_COUNT, 17'd131071);
                default:
                begin
                    if ($urandom_range(0, 1) == 0)
                        write_reg(CFG_TARGET_RECORD, pick_target());
                    if ($urandom_range(0, 1) == 0)
                        write_reg(CFG_RECORD_COUNT, pick_count());
                end
            endcase
            tx_gaps   = $urandom_range(0, 2) != 0;
            rx_stalls = $urandom_range(0, 2) != 0;
            if (phase_no == 2)
            begin
                // sender keeps going while the receiver sits out
                tx_gaps = 1'b0;
                hold_asks++;
            end
            phase_end = items_sent + $urandom_range(120, 260);
            while (items_sent < phase_end)
                push_random_record();
            phase_no++;
        end

        no_idling = 1'b1;
        settle();
        finale   = finale_t'($urandom_range(0, 2));
        rec_size = $urandom_range(1, 8);
        case (finale)
            END_BY_TARGET:
            begin
                write_reg(CFG_TARGET_RECORD, {1'b0, next_rec});
                push_record(rec_size, rec_size, 1'b0, 1'b0, 1'b0);
            end
            END_BY_COUNT:
            begin
                write_reg(CFG_RECORD_COUNT, {1'b0, next_rec} + 1'b1);
                push_record(rec_size, rec_size, 1'b0, 1'b0, 1'b0);
            end
            default:
                push_record(32'd0, 40, 1'b0, 1'b0, 1'b0);
        endcase
        // dropped once extraction has ended, still payload for an open record
        repeat (4) push_byte(BYTE_W'($urandom_range(0, 255)));

        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (backlog == 0);
        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && backlog == 0)
            $display("tb_hidden_record_bit_extractor: clean");
        else
            $display("tb_hidden_record_bit_extractor: errors");
        $finish;
    end

endmodule
